FILE: design/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms for the frame sequencer RTL.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// a implies b in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("implication check failed");

// a implies b in the following cycle
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_IMPL(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)

`endif

`endif

FILE: design/i2cfs_pkg.sv
// ============================================================================
// i2cfs_pkg
// Types, codes and helpers shared by the I2C master frame sequencer.
// ============================================================================
package i2cfs_pkg;

    // Stream widths
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 2;

    // Address byte forming
    localparam logic [7:0] ADDR_WR_MASK = 8'hFE;
    localparam logic [7:0] ADDR_RD_BIT  = 8'h01;

    // Item kinds carried in the input tuser
    typedef enum logic [1:0] {
        FUNC_WRITE      = 2'd0,
        FUNC_READ       = 2'd1,
        FUNC_WRITE_READ = 2'd2,
        FUNC_EVENT      = 2'd3
    } func_t;

    // Result status
    typedef enum logic [1:0] {
        STATUS_ACCEPTED = 2'd0,
        STATUS_BUSY     = 2'd1,
        STATUS_EVENT    = 2'd2
    } status_t;

    // Bus actions
    typedef enum logic [2:0] {
        ACT_NONE       = 3'd0,
        ACT_START      = 3'd1,
        ACT_DATA       = 3'd2,
        ACT_RESTART    = 3'd3,
        ACT_STOP       = 3'd4,
        ACT_ABORT_STOP = 3'd5,
        ACT_DUMMY_READ = 3'd6
    } action_t;

    // Classified item, front to back
    typedef struct packed {
        func_t       func;
        logic [6:0]  addr;
        logic [7:0]  addr_wr;
        logic [7:0]  addr_rd;
        logic [7:0]  wcnt;
        logic [7:0]  rcnt;
        logic        rcnt_one;
        logic [7:0]  txb;
        logic [7:0]  rxd;
        logic        done;
        logic        nak;
    } item_t;

    // One result item
    typedef struct packed {
        status_t     status;
        action_t     action;
        logic [7:0]  bus_byte;
        logic        send_nak;
        logic        transmit_mode;
        logic        rx_valid;
        logic [7:0]  rx_byte;
        logic        frame_active;
        logic        nak_seen;
    } result_t;

    // Address byte with the read bit set
    function automatic logic [7:0] addr_read(input logic [6:0] a);
        addr_read = {a, 1'b0} | ADDR_RD_BIT;
    endfunction

    // Address byte with the read bit clear
    function automatic logic [7:0] addr_write(input logic [6:0] a);
        addr_write = {a, 1'b0} & ADDR_WR_MASK;
    endfunction

endpackage

FILE: design/i2cfs_front.sv
// ============================================================================
// i2cfs_front
// Unpacks an input item, normalizes the read count and forms address bytes.
// ============================================================================
module i2cfs_front
(
    input  logic [i2cfs_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [i2cfs_pkg::S_TUSER_W-1:0] s_tuser,
    output i2cfs_pkg::item_t                item
);

    logic [7:0] rcnt_raw;

    assign rcnt_raw = s_tdata[22:15];

    // Field unpack and classification
    always_comb
    begin
        item.func     = i2cfs_pkg::func_t'(s_tuser);
        item.addr     = s_tdata[6:0];
        item.addr_wr  = i2cfs_pkg::addr_write(s_tdata[6:0]);
        item.addr_rd  = i2cfs_pkg::addr_read(s_tdata[6:0]);
        item.wcnt     = s_tdata[14:7];
        // zero read count counts as one
        item.rcnt     = (rcnt_raw == 8'd0) ? 8'd1 : rcnt_raw;
        item.rcnt_one = (rcnt_raw == 8'd0) || (rcnt_raw == 8'd1);
        item.txb      = s_tdata[30:23];
        item.rxd      = s_tdata[38:31];
        item.done     = s_tdata[39];
        item.nak      = s_tdata[40];
    end

endmodule

FILE: design/i2cfs_queue.sv
// ============================================================================
// i2cfs_queue
// Two-entry item queue between the front and back parts.
// ============================================================================
`include "assert_macros.svh"

module i2cfs_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  i2cfs_pkg::item_t push_item,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output i2cfs_pkg::item_t head
);

    i2cfs_pkg::item_t entry_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = entry_reg[rd_ptr_reg];

    // Fill count
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    // Pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

    `ASSERT_IMPL(a_count_range, clk, rst_n, 1'b1, count_reg != 2'd3)
    `ASSERT_IMPL(a_no_overflow, clk, rst_n, full, !push)
    `ASSERT_IMPL(a_no_underflow, clk, rst_n, pop, not_empty)

endmodule

FILE: design/i2cfs_back.sv
// ============================================================================
// i2cfs_back
// Frame state update and registered result for one item per cycle while the output is not stalled.
// ============================================================================
`include "assert_macros.svh"

module i2cfs_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  i2cfs_pkg::item_t  q_item,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output i2cfs_pkg::result_t out_result
);

    // Frame state
    logic       in_progress_reg, in_progress_next;
    logic       write_phase_reg, write_phase_next;
    logic       read_phase_reg, read_phase_next;
    logic       combined_reg, combined_next;
    logic       first_read_reg, first_read_next;
    logic [7:0] to_send_reg, to_send_next;
    logic [7:0] to_recv_reg, to_recv_next;
    logic [6:0] target_reg, target_next;
    logic       nak_flag_reg, nak_flag_next;
    logic       nak_mode_reg, nak_mode_next;
    logic       tx_dir_reg, tx_dir_next;

    logic               out_valid_reg;
    i2cfs_pkg::result_t result_reg;
    i2cfs_pkg::result_t result_next;

    assign q_pop      = q_valid && (!out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

    // Next state and result for the head item
    always_comb
    begin
        in_progress_next = in_progress_reg;
        write_phase_next = write_phase_reg;
        read_phase_next  = read_phase_reg;
        combined_next    = combined_reg;
        first_read_next  = first_read_reg;
        to_send_next     = to_send_reg;
        to_recv_next     = to_recv_reg;
        target_next      = target_reg;
        nak_flag_next    = nak_flag_reg;
        nak_mode_next    = nak_mode_reg;
        tx_dir_next      = tx_dir_reg;

        result_next.status   = i2cfs_pkg::STATUS_EVENT;
        result_next.action   = i2cfs_pkg::ACT_NONE;
        result_next.bus_byte = 8'd0;
        result_next.rx_valid = 1'b0;
        result_next.rx_byte  = 8'd0;

        unique case (q_item.func) inside
            i2cfs_pkg::FUNC_WRITE, i2cfs_pkg::FUNC_READ, i2cfs_pkg::FUNC_WRITE_READ:
            begin
                if (in_progress_reg)
                begin
                    result_next.status = i2cfs_pkg::STATUS_BUSY;
                end
                else
                begin
                    // new frame: clear frame bits, send start with address
                    result_next.status = i2cfs_pkg::STATUS_ACCEPTED;
                    result_next.action = i2cfs_pkg::ACT_START;
                    write_phase_next   = 1'b0;
                    read_phase_next    = 1'b0;
                    combined_next      = 1'b0;
                    first_read_next    = 1'b0;
                    in_progress_next   = 1'b1;
                    tx_dir_next        = 1'b1;
                    unique case (q_item.func)
                        i2cfs_pkg::FUNC_WRITE:
                        begin
                            write_phase_next     = 1'b1;
                            to_send_next         = q_item.wcnt;
                            result_next.bus_byte = q_item.addr_wr;
                        end
                        i2cfs_pkg::FUNC_READ:
                        begin
                            read_phase_next      = 1'b1;
                            to_recv_next         = q_item.rcnt;
                            nak_mode_next        = q_item.rcnt_one;
                            result_next.bus_byte = q_item.addr_rd;
                        end
                        i2cfs_pkg::FUNC_WRITE_READ:
                        begin
                            write_phase_next     = 1'b1;
                            read_phase_next      = 1'b1;
                            combined_next        = 1'b1;
                            to_send_next         = q_item.wcnt;
                            to_recv_next         = q_item.rcnt;
                            target_next          = q_item.addr;
                            nak_mode_next        = q_item.rcnt_one;
                            result_next.bus_byte = q_item.addr_wr;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
                // byte-complete event; ignored while idle
                if (!in_progress_reg)
                begin
                end
                else if (q_item.nak && write_phase_reg)
                begin
                    nak_flag_next      = 1'b1;
                    in_progress_next   = 1'b0;
                    write_phase_next   = 1'b0;
                    read_phase_next    = 1'b0;
                    combined_next      = 1'b0;
                    first_read_next    = 1'b0;
                    result_next.action = i2cfs_pkg::ACT_ABORT_STOP;
                end
                else if (q_item.done)
                begin
                    if (write_phase_reg)
                    begin
                        if (to_send_reg != 8'd0)
                        begin
                            to_send_next         = to_send_reg - 8'd1;
                            result_next.action   = i2cfs_pkg::ACT_DATA;
                            result_next.bus_byte = q_item.txb;
                        end
                        else if (!combined_reg)
                        begin
                            result_next.action = i2cfs_pkg::ACT_STOP;
                            in_progress_next   = 1'b0;
                        end
                        else
                        begin
                            write_phase_next     = 1'b0;
                            result_next.action   = i2cfs_pkg::ACT_RESTART;
                            result_next.bus_byte = i2cfs_pkg::addr_read(target_reg);
                        end
                    end
                    else if (read_phase_reg)
                    begin
                        if (first_read_reg)
                        begin
                            result_next.rx_valid = 1'b1;
                            result_next.rx_byte  = q_item.rxd;
                            if (to_recv_reg != 8'd0)
                            begin
                                if (to_recv_reg == 8'd1)
                                    nak_mode_next = 1'b1;
                                to_recv_next = to_recv_reg - 8'd1;
                            end
                            else
                            begin
                                result_next.action = i2cfs_pkg::ACT_STOP;
                                in_progress_next   = 1'b0;
                            end
                        end
                        else
                        begin
                            // dummy read turns the bus around
                            tx_dir_next        = 1'b0;
                            first_read_next    = 1'b1;
                            to_recv_next       = to_recv_reg - 8'd1;
                            result_next.action = i2cfs_pkg::ACT_DUMMY_READ;
                        end
                    end
                end
            end
        endcase

        result_next.send_nak      = nak_mode_next;
        result_next.transmit_mode = tx_dir_next;
        result_next.frame_active  = in_progress_next;
        result_next.nak_seen      = nak_flag_next;
    end

    // State and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_progress_reg <= 1'b0;
            write_phase_reg <= 1'b0;
            read_phase_reg  <= 1'b0;
            combined_reg    <= 1'b0;
            first_read_reg  <= 1'b0;
            to_send_reg     <= 8'd0;
            to_recv_reg     <= 8'd0;
            target_reg      <= 7'd0;
            nak_flag_reg    <= 1'b0;
            nak_mode_reg    <= 1'b0;
            tx_dir_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                in_progress_reg <= in_progress_next;
                write_phase_reg <= write_phase_next;
                read_phase_reg  <= read_phase_next;
                combined_reg    <= combined_next;
                first_read_reg  <= first_read_next;
                to_send_reg     <= to_send_next;
                to_recv_reg     <= to_recv_next;
                target_reg      <= target_next;
                nak_flag_reg    <= nak_flag_next;
                nak_mode_reg    <= nak_mode_next;
                tx_dir_reg      <= tx_dir_next;
                out_valid_reg   <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
            result_reg <= result_next;
    end

    `ASSERT_IMPL(a_rx_dir, clk, rst_n, first_read_reg, !tx_dir_reg)
    `ASSERT_NEXT(a_nak_sticky, clk, rst_n, nak_flag_reg, nak_flag_reg)
    `ASSERT_NEXT(a_busy_keeps_frame, clk, rst_n,
                 q_pop && in_progress_reg && (q_item.func != i2cfs_pkg::FUNC_EVENT),
                 in_progress_reg)

endmodule

FILE: design/i2c_master_frame_sequencer_core.sv
// ============================================================================
// i2c_master_frame_sequencer_core
// I2C master frame sequencer: start commands and byte-complete events in,
// one bus step result out per item.
// ============================================================================
// The block takes one item per clock cycle while m_tready does not stall the
// output, and returns exactly one result item for each. An accepted item is
// classified and written into a two-entry queue; the back part pops it from
// the queue, updates the frame state and loads the output register, which
// presents the result on m_tvalid. The single frame-state update in the
// back part sets the one-item-per-cycle figure. The queue and the output
// register let the input keep accepting while a result waits on m_tready;
// s_tready drops only when the queue holds two items.
module i2c_master_frame_sequencer_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // slave_address[6:0], write_count[14:7], read_count[22:15], tx_byte[30:23],
    // rx_data[38:31], transfer_done[39], ack_missing[40], zero[47:41]
    input  logic [i2cfs_pkg::S_TDATA_W-1:0] s_tdata,
    // func[1:0]
    input  logic [i2cfs_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // bus_action[2:0], bus_byte[10:3], send_nak[11], transmit_mode[12],
    // rx_valid[13], rx_byte[21:14], frame_active[22], nak_seen[23]
    output logic [i2cfs_pkg::M_TDATA_W-1:0] m_tdata,
    // cmd_status[1:0]
    output logic [i2cfs_pkg::M_TUSER_W-1:0] m_tuser
);

    i2cfs_pkg::item_t   front_item;
    i2cfs_pkg::item_t   head_item;
    i2cfs_pkg::result_t result;
    logic               q_full;
    logic               q_not_empty;
    logic               q_pop;

    assign s_tready = !q_full;

    // Classify
    i2cfs_front u_front
    (
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .item    (front_item)
    );

    // Decoupling queue
    i2cfs_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_tvalid && !q_full),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (head_item)
    );

    // Execute
    i2cfs_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_not_empty),
        .q_item     (head_item),
        .q_pop      (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    // Result pack
    assign m_tuser = result.status;
    assign m_tdata = {result.nak_seen, result.frame_active, result.rx_byte,
                      result.rx_valid, result.transmit_mode, result.send_nak,
                      result.bus_byte, result.action};

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for i2c_master_frame_sequencer_core
// Drives start commands and byte-complete events over the input stream and
// checks each result item against a cycle-free frame predictor kept in a
// scoreboard. The run covers a directed opening, then random well-formed
// frames mixed with noise, in four idling phases.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // ------------------------------------------------------------------------
    // Frame predictor and store of expected result items
    // ------------------------------------------------------------------------
    class frame_scoreboard;
        // predicted frame state
        bit         busy;
        bit         wr_phase;
        bit         rd_phase;
        bit         combo;
        bit         first_rd;
        logic [7:0] send_left;
        logic [7:0] recv_left;
        logic [6:0] tgt_addr;
        bit         nak_sticky;
        bit         nak_mode;
        bit         tx_dir;

        i2cfs_pkg::result_t expected_q[$];
        int                 mismatches;

        function void clear_frame();
            wr_phase = 1'b0;
            rd_phase = 1'b0;
            combo    = 1'b0;
            first_rd = 1'b0;
        endfunction

        // Predict the result of one accepted item; returns 0 for an event the
        // block ignores because no frame is active.
        function bit note_input(i2cfs_pkg::func_t f, logic [47:0] d);
            logic [6:0]         addr;
            logic [7:0]         wcnt;
            logic [7:0]         rcnt;
            logic [7:0]         txb;
            logic [7:0]         rxd;
            logic               done;
            logic               nak;
            i2cfs_pkg::result_t r;
            bit                 effective;
            addr = d[6:0];
            wcnt = d[14:7];
            rcnt = d[22:15];
            txb  = d[30:23];
            rxd  = d[38:31];
            done = d[39];
            nak  = d[40];
            r = '0;
            effective = 1'b1;
            if (rcnt == 8'd0)
                rcnt = 8'd1;

            if (f != i2cfs_pkg::FUNC_EVENT)
            begin
                if (busy)
                    r.status = i2cfs_pkg::STATUS_BUSY;
                else
                begin
                    r.status = i2cfs_pkg::STATUS_ACCEPTED;
                    clear_frame();
                    busy     = 1'b1;
                    tx_dir   = 1'b1;
                    r.action = i2cfs_pkg::ACT_START;
                    case (f)
                        i2cfs_pkg::FUNC_WRITE:
                        begin
                            wr_phase   = 1'b1;
                            send_left  = wcnt;
                            r.bus_byte = {addr, 1'b0};
                        end
                        i2cfs_pkg::FUNC_READ:
                        begin
                            rd_phase   = 1'b1;
                            recv_left  = rcnt;
                            nak_mode   = (rcnt == 8'd1);
                            r.bus_byte = {addr, 1'b1};
                        end
                        default:
                        begin
                            wr_phase   = 1'b1;
                            rd_phase   = 1'b1;
                            combo      = 1'b1;
                            send_left  = wcnt;
                            recv_left  = rcnt;
                            tgt_addr   = addr;
                            nak_mode   = (rcnt == 8'd1);
                            r.bus_byte = {addr, 1'b0};
                        end
                    endcase
                end
            end
            else
            begin
                r.status = i2cfs_pkg::STATUS_EVENT;
                if (!busy)
                    effective = 1'b0;
                else if (nak && wr_phase)
                begin
                    // missing acknowledge while writing aborts the frame
                    nak_sticky = 1'b1;
                    busy       = 1'b0;
                    clear_frame();
                    r.action   = i2cfs_pkg::ACT_ABORT_STOP;
                end
                else if (done)
                begin
                    if (wr_phase)
                    begin
                        if (send_left != 8'd0)
                        begin
                            send_left  = send_left - 8'd1;
                            r.action   = i2cfs_pkg::ACT_DATA;
                            r.bus_byte = txb;
                        end
                        else if (!combo)
                        begin
                            r.action = i2cfs_pkg::ACT_STOP;
                            busy     = 1'b0;
                        end
                        else
                        begin
                            wr_phase   = 1'b0;
                            r.action   = i2cfs_pkg::ACT_RESTART;
                            r.bus_byte = {tgt_addr, 1'b1};
                        end
                    end
                    else if (rd_phase)
                    begin
                        if (first_rd)
                        begin
                            r.rx_valid = 1'b1;
                            r.rx_byte  = rxd;
                            if (recv_left != 8'd0)
                            begin
                                if (recv_left == 8'd1)
                                    nak_mode = 1'b1;
                                recv_left = recv_left - 8'd1;
                            end
                            else
                            begin
                                r.action = i2cfs_pkg::ACT_STOP;
                                busy     = 1'b0;
                            end
                        end
                        else
                        begin
                            // dummy read turns the bus around
                            tx_dir    = 1'b0;
                            first_rd  = 1'b1;
                            recv_left = recv_left - 8'd1;
                            r.action  = i2cfs_pkg::ACT_DUMMY_READ;
                        end
                    end
                end
            end

            r.send_nak      = nak_mode;
            r.transmit_mode = tx_dir;
            r.frame_active  = busy;
            r.nak_seen      = nak_sticky;
            expected_q.push_back(r);
            return effective;
        endfunction

        // Compare one result item with the oldest expectation
        function void check_result(logic [1:0] st, logic [23:0] d);
            i2cfs_pkg::result_t e;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result item with nothing expected:", $realtime,
                             " status=%0d data=%06h", st, d);
                return;
            end
            e = expected_q.pop_front();
            if (st != e.status || d[2:0] != e.action || d[10:3] != e.bus_byte ||
                d[11] != e.send_nak || d[12] != e.transmit_mode || d[13] != e.rx_valid ||
                d[21:14] != e.rx_byte || d[22] != e.frame_active || d[23] != e.nak_seen)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: mismatch, expected st=%0d act=%0d byte=%02h",
                             $realtime, e.status, e.action, e.bus_byte,
                             " nak=%0b tx=%0b rxv=%0b rxb=%02h", e.send_nak,
                             e.transmit_mode, e.rx_valid, e.rx_byte,
                             " act_fr=%0b nak_seen=%0b", e.frame_active, e.nak_seen);
                    $display("%0t:           actual   st=%0d act=%0d byte=%02h",
                             $realtime, st, d[2:0], d[10:3],
                             " nak=%0b tx=%0b rxv=%0b rxb=%02h", d[11], d[12], d[13],
                             d[21:14], " act_fr=%0b nak_seen=%0b", d[22], d[23]);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and DUT
    // ------------------------------------------------------------------------
    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [i2cfs_pkg::S_TDATA_W-1:0] s_tdata;
    logic [i2cfs_pkg::S_TUSER_W-1:0] s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [i2cfs_pkg::M_TDATA_W-1:0] m_tdata;
    logic [i2cfs_pkg::M_TUSER_W-1:0] m_tuser;

    frame_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  items_sent;
    logic hold_rx;

    i2c_master_frame_sequencer_core DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock, 12 ns period
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #3ms;
        $display("tb_top failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls plus one long hold-off
    // ------------------------------------------------------------------------
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_rx)
                m_tready <= 1'b0;
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Long receiver hold-off while the sender keeps offering items
    initial
    begin
        hold_rx <= 1'b0;
        wait (items_sent >= 150);
        @(posedge clk);
        hold_rx <= 1'b1;
        repeat (400) @(posedge clk);
        hold_rx <= 1'b0;
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata);
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [47:0] pack_item(logic [6:0] addr, logic [7:0] wcnt,
                                              logic [7:0] rcnt, logic [7:0] txb,
                                              logic [7:0] rxd, logic done, logic nak);
        return {7'd0, nak, done, rxd, txb, rcnt, wcnt, addr};
    endfunction

    // Offer one item with optional idle gap; returns 0 for an ignored event
    task automatic offer(input i2cfs_pkg::func_t f, input logic [47:0] d,
                         output bit effective);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= d;
        do
            @(posedge clk);
        while (!s_tready);
        effective = sb.note_input(f, d);
        items_sent++;
    endtask

    // Byte count for a frame: mostly short, now and then the full range
    function automatic logic [7:0] pick_count();
        int p;
        p = $urandom_range(63);
        if (p == 0)
            return 8'($urandom_range(255));
        else if (p < 16)
            return 8'($urandom_range(20, 5));
        else
            return 8'($urandom_range(4));
    endfunction

    // One random item, shaped by the predicted frame state
    task automatic send_random(output bit effective);
        i2cfs_pkg::func_t f;
        logic [6:0]       a;
        logic [7:0]       w;
        logic [7:0]       r;
        logic [7:0]       t;
        logic [7:0]       x;
        logic             dn;
        logic             nk;
        int               pick;
        a    = 7'($urandom_range(127));
        w    = pick_count();
        r    = pick_count();
        t    = 8'($urandom_range(255));
        x    = 8'($urandom_range(255));
        dn   = 1'b1;
        nk   = 1'b0;
        pick = $urandom_range(99);
        if (pick < 6)
        begin
            // noise: every field random
            f  = i2cfs_pkg::func_t'($urandom_range(3));
            w  = 8'($urandom_range(255));
            r  = 8'($urandom_range(255));
            dn = 1'($urandom_range(1));
            nk = 1'($urandom_range(1));
        end
        else if (sb.busy)
        begin
            if (pick < 10)
                f = i2cfs_pkg::func_t'($urandom_range(2));
            else
            begin
                f  = i2cfs_pkg::FUNC_EVENT;
                dn = ($urandom_range(99) >= 5);
                nk = ($urandom_range(99) < 3);
            end
        end
        else if (pick < 12)
            f = i2cfs_pkg::FUNC_EVENT;
        else
            f = i2cfs_pkg::func_t'($urandom_range(2));
        offer(f, pack_item(a, w, r, t, x, dn, nk), effective);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        bit eff;
        int n;
        sb             = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        items_sent     = 0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed opening
        // event with no frame active is ignored, even with a missing ack
        offer(i2cfs_pkg::FUNC_EVENT,
              pack_item(7'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1), eff);
        offer(i2cfs_pkg::FUNC_WRITE,
              pack_item(7'h7F, 8'd1, 8'd0, 8'h00, 8'h00, 1'b0, 1'b0), eff);
        // start while busy is refused
        offer(i2cfs_pkg::FUNC_READ,
              pack_item(7'h11, 8'd0, 8'd3, 8'h00, 8'h00, 1'b0, 1'b0), eff);
        // event without transfer done does nothing
        offer(i2cfs_pkg::FUNC_EVENT,
              pack_item(7'h00, 8'd0, 8'd0, 8'h3C, 8'h00, 1'b0, 1'b0), eff);
        offer(i2cfs_pkg::FUNC_EVENT,
              pack_item(7'h00, 8'd0, 8'd0, 8'hFF, 8'h00, 1'b1, 1'b0), eff);
        offer(i2cfs_pkg::FUNC_EVENT,
              pack_item(7'h00, 8'd0, 8'd0, 8'h12, 8'h00, 1'b1, 1'b0), eff);
        // read with zero count runs as a one-byte read
        offer(i2cfs_pkg::FUNC_READ,
              pack_item(7'h00, 8'd0, 8'd0, 8'h00, 8'h00, 1'b0, 1'b0), eff);
        // missing ack in the read phase is ignored
        offer(i2cfs_pkg::FUNC_EVENT,
              pack_item(7'h00, 8'd0, 8'd0, 8'h00, 8'h00, 1'b1, 1'b1), eff);
        offer(i2cfs_pkg::FUNC_EVENT,
              pack_item(7'h00, 8'd0, 8'd0, 8'h00, 8'hFF, 1'b1, 1'b0), eff);
        // write then read: restart, dummy read, two bytes
        offer(i2cfs_pkg::FUNC_WRITE_READ,
              pack_item(7'h55, 8'd0, 8'd2, 8'h00, 8'h00, 1'b0, 1'b0), eff);
        offer(i2cfs_pkg::FUNC_EVENT,
              pack_item(7'h00, 8'd0, 8'd0, 8'h77, 8'h00, 1'b1, 1'b0), eff);
        offer(i2cfs_pkg::FUNC_EVENT,
              pack_item(7'h00, 8'd0, 8'd0, 8'h00, 8'h00, 1'b1, 1'b1), eff);
        offer(i2cfs_pkg::FUNC_EVENT,
              pack_item(7'h00, 8'd0, 8'd0, 8'h00, 8'h00, 1'b1, 1'b0), eff);
        offer(i2cfs_pkg::FUNC_EVENT,
              pack_item(7'h00, 8'd0, 8'd0, 8'h00, 8'hA5, 1'b1, 1'b0), eff);
        // missing ack while writing aborts and sets the sticky flag
        offer(i2cfs_pkg::FUNC_WRITE,
              pack_item(7'h00, 8'd3, 8'd0, 8'h00, 8'h00, 1'b0, 1'b0), eff);
        offer(i2cfs_pkg::FUNC_EVENT,
              pack_item(7'h00, 8'd0, 8'd0, 8'h00, 8'h00, 1'b1, 1'b0), eff);
        offer(i2cfs_pkg::FUNC_EVENT,
              pack_item(7'h00, 8'd0, 8'd0, 8'h00, 8'h00, 1'b0, 1'b1), eff);
        // write start leaves the NAK mode as it was
        offer(i2cfs_pkg::FUNC_WRITE,
              pack_item(7'h2A, 8'd0, 8'd0, 8'h00, 8'h00, 1'b0, 1'b0), eff);
        offer(i2cfs_pkg::FUNC_EVENT,
              pack_item(7'h00, 8'd0, 8'd0, 8'h00, 8'h00, 1'b1, 1'b0), eff);

        // Random part in four idling phases
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 58; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 58; end
                default: begin send_idle_pct = 9;  recv_stall_pct = 9;  end
            endcase
            n = 0;
            while (n < 480)
            begin
                send_random(eff);
                if (eff)
                    n++;
            end
            // sender pauses until every expected result has come
            s_tvalid <= 1'b0;
            while (sb.expected_q.size() != 0)
                @(posedge clk);
            @(posedge clk);
        end

        // Drain
        recv_stall_pct = 0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
